>>> src/ep2c_pkg.sv
// ep2c_pkg: shared widths, constants, types and a small helper function
// for the epoch seconds to calendar pipeline; used by every ep2c module
// but ep2c_cdiv, and by the top level. no dependencies.
package ep2c_pkg;

    // field widths
    localparam int SECS_W   = 39;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // pipeline shape
    localparam int STAGES     = 14;
    localparam int SPLIT_LAST = 3;     // last stage of the day split
    localparam int UPPER_N    = STAGES - SPLIT_LAST - 1;

    // day split: floor(secs / 86400) as floor((secs >>> 7) / 675)
    localparam int SEC_LO_W = 7;
    localparam int U_W      = 33;
    localparam int DAYQ_W   = 23;
    localparam int REM_W    = 17;
    localparam int DAY_DIVISOR  = 675;
    localparam int DAY_SHIFT    = 40;
    // 675 * 3181458, makes the shifted seconds non-negative
    localparam logic [U_W-1:0] DAY_BIAS = 33'd2147484150;

    // julian day arithmetic
    localparam int Z_W = 24;
    // z = biased quotient - 3181458 + 2440588
    localparam logic signed [Z_W-1:0] Z_OFFSET    = 24'sd740870;
    localparam logic signed [Z_W-1:0] GREG_START  = 24'sd2299161;
    localparam logic signed [25:0]    ALPHA_BASE  = 26'sd7468865;
    localparam logic signed [Z_W-1:0] B_OFFSET    = 24'sd1524;
    localparam logic signed [31:0]    C_BASE      = 32'sd12210;
    localparam logic signed [15:0]    YEAR_LATE   = 16'sd4716;
    localparam logic signed [15:0]    YEAR_EARLY  = 16'sd4715;

    localparam int ALPHA_N_W     = 25;
    localparam int ALPHA_Q_W     = 7;
    localparam int ALPHA_DIVISOR = 146097;
    localparam int ALPHA_SHIFT   = 40;

    localparam int C_N_W     = 30;
    localparam int C_Q_W     = 15;
    localparam int C_DIVISOR = 36525;
    localparam int C_SHIFT   = 45;

    localparam int BD_W   = 10;
    localparam int BMAG_W = 9;
    localparam int EMAG_W = 4;

    // smallest b-d giving each month index: ceil(30.6001 * k)
    localparam logic [BMAG_W-1:0] E_THRESH [16] = '{
        9'd0,   9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215,
        9'd245, 9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
    };

    // floor(30.6001 * k)
    localparam logic [BMAG_W-1:0] E_TERM [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    // time of day
    localparam int MIN_OF_DAY_W = 11;
    localparam logic [14:0] DIV15_RECIP = 15'd17477;   // ceil(2^18 / 15)

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } tod_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // exact x / 60 for x below 86400: (x / 4) / 15 by reciprocal
    function automatic logic [MIN_OF_DAY_W-1:0] div60(input logic [REM_W-1:0] x);
        logic [29:0] prod;
        prod = 30'(x[REM_W-1:2]) * 30'(DIV15_RECIP);
        return prod[28:18];
    endfunction

endpackage

>>> src/ep2c_cdiv.sv
// ep2c_cdiv: two-stage unsigned divide by a constant, reciprocal estimate
// then one correction step; standalone, no package needed.
module ep2c_cdiv #(
    parameter int unsigned DIVISOR = 675,
    parameter int unsigned N_W     = 33,
    parameter int unsigned Q_W     = 23,
    parameter int unsigned SHIFT   = 40
) (
    input  logic                         clk,
    input  logic [1:0]                   adv,
    input  logic [N_W-1:0]               num,
    output logic [Q_W-1:0]               quo,
    output logic [$clog2(DIVISOR)-1:0]   rmd
);

    localparam logic [63:0]  RECIP = (64'd1 << SHIFT) / 64'(DIVISOR);
    localparam int unsigned  M_W   = $clog2(RECIP + 64'd1);
    localparam int unsigned  P_W   = N_W + M_W;
    localparam int unsigned  R_W   = $clog2(DIVISOR);

    logic [P_W-1:0] prod;
    logic [N_W-1:0] num_reg;
    logic [Q_W-1:0] qest_reg;
    logic [N_W-1:0] back;
    logic [N_W-1:0] diff;
    logic           fix;
    logic [Q_W-1:0] quo_reg;
    logic [R_W-1:0] rmd_reg;

    // estimate is the true quotient or one below it
    assign prod = P_W'(num) * P_W'(RECIP);
    assign back = N_W'(qest_reg) * N_W'(DIVISOR);
    assign diff = num_reg - back;
    assign fix  = (diff >= N_W'(DIVISOR));

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            num_reg  <= num;
            qest_reg <= prod[SHIFT +: Q_W];
        end
        if (adv[1])
        begin
            quo_reg <= fix ? qest_reg + Q_W'(1) : qest_reg;
            rmd_reg <= fix ? R_W'(diff - N_W'(DIVISOR)) : R_W'(diff);
        end
    end

    assign quo = quo_reg;
    assign rmd = rmd_reg;

endmodule

>>> src/ep2c_split.sv
// ep2c_split: input register and floor split of seconds into a day
// quotient and seconds of day; uses ep2c_pkg and ep2c_cdiv.
module ep2c_split (
    input  logic                                clk,
    input  logic [ep2c_pkg::SPLIT_LAST:0]       adv,
    input  logic signed [ep2c_pkg::SECS_W-1:0]  epoch_seconds,
    output logic [ep2c_pkg::DAYQ_W-1:0]         dayq,
    output logic [ep2c_pkg::REM_W-1:0]          rem
);
    import ep2c_pkg::*;

    localparam int R_W = $clog2(DAY_DIVISOR);

    logic signed [SECS_W-1:0]   secs_reg;
    logic signed [31:0]         q1;
    logic signed [U_W:0]        u_sum;
    logic [U_W-1:0]             u_reg;
    logic [SEC_LO_W-1:0]        lo1_reg;
    logic [SEC_LO_W-1:0]        lo2_reg;
    logic [SEC_LO_W-1:0]        lo3_reg;
    logic [R_W-1:0]             rmd;

    // arithmetic shift is already a floor
    assign q1    = 32'(secs_reg >>> SEC_LO_W);
    assign u_sum = (U_W+1)'(q1) + (U_W+1)'(DAY_BIAS);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            secs_reg <= epoch_seconds;
        end
        if (adv[1])
        begin
            u_reg   <= u_sum[U_W-1:0];
            lo1_reg <= secs_reg[SEC_LO_W-1:0];
        end
        if (adv[2])
        begin
            lo2_reg <= lo1_reg;
        end
        if (adv[3])
        begin
            lo3_reg <= lo2_reg;
        end
    end

    ep2c_cdiv #(
        .DIVISOR (DAY_DIVISOR),
        .N_W     (U_W),
        .Q_W     (DAYQ_W),
        .SHIFT   (DAY_SHIFT)
    ) u_day_div (
        .clk (clk),
        .adv (adv[3:2]),
        .num (u_reg),
        .quo (dayq),
        .rmd (rmd)
    );

    assign rem = {rmd, lo3_reg};

endmodule

>>> src/ep2c_tod.sv
// ep2c_tod: hour, minute and second from seconds of day, with a delay
// line to line up with the date path; uses ep2c_pkg.
module ep2c_tod (
    input  logic                           clk,
    input  logic [ep2c_pkg::UPPER_N-1:0]   adv,
    input  logic [ep2c_pkg::REM_W-1:0]     rem,
    output ep2c_pkg::tod_t                 tod
);
    import ep2c_pkg::*;

    localparam int DLY = UPPER_N - 4;

    logic [REM_W-1:0]        rem4_reg;
    logic [REM_W-1:0]        rem5_reg;
    logic [MIN_OF_DAY_W-1:0] mt5_reg;
    logic [MIN_OF_DAY_W-1:0] mt6_reg;
    logic [HOUR_W-1:0]       hr6_reg;
    logic [SECOND_W-1:0]     sec6_reg;
    logic [MIN_OF_DAY_W-1:0] hr_c;
    logic [REM_W-1:0]        sec_c;
    logic [MIN_OF_DAY_W-1:0] min_c;
    tod_t                    tod7_reg;
    tod_t                    dly_reg [DLY];

    assign sec_c = rem5_reg - REM_W'(mt5_reg) * REM_W'(60);
    assign hr_c  = div60(REM_W'(mt5_reg));
    assign min_c = mt6_reg - MIN_OF_DAY_W'(hr6_reg) * MIN_OF_DAY_W'(60);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rem4_reg <= rem;
        end
        if (adv[1])
        begin
            rem5_reg <= rem4_reg;
            mt5_reg  <= div60(rem4_reg);
        end
        if (adv[2])
        begin
            mt6_reg  <= mt5_reg;
            hr6_reg  <= hr_c[HOUR_W-1:0];
            sec6_reg <= sec_c[SECOND_W-1:0];
        end
        if (adv[3])
        begin
            tod7_reg.hour   <= hr6_reg;
            tod7_reg.minute <= min_c[MINUTE_W-1:0];
            tod7_reg.second <= sec6_reg;
        end
        if (adv[4])
        begin
            dly_reg[0] <= tod7_reg;
        end
        for (int i = 1; i < DLY; i++)
        begin
            if (adv[4+i])
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign tod = dly_reg[DLY-1];

endmodule

>>> src/ep2c_date.sv
// ep2c_date: julian day number to calendar year, month and day, pipelined
// over ten stages; uses ep2c_pkg and ep2c_cdiv.
module ep2c_date (
    input  logic                           clk,
    input  logic [ep2c_pkg::UPPER_N-1:0]   adv,
    input  logic [ep2c_pkg::DAYQ_W-1:0]    dayq,
    output ep2c_pkg::date_t                date
);
    import ep2c_pkg::*;

    // stage: julian day and gregorian test
    logic signed [Z_W-1:0]   z_c;
    logic                    greg_c;
    logic signed [25:0]      nal_full;
    logic [ALPHA_N_W-1:0]    nal_c;
    logic signed [Z_W-1:0]   z4_reg;
    logic                    greg4_reg;
    logic [ALPHA_N_W-1:0]    nal_reg;
    logic signed [Z_W-1:0]   z5_reg;
    logic                    greg5_reg;
    logic signed [Z_W-1:0]   z6_reg;
    logic                    greg6_reg;
    logic [ALPHA_Q_W-1:0]    alpha;

    // stage: b and the century numerator
    logic signed [Z_W-1:0]   alpha_adj;
    logic signed [Z_W-1:0]   a_c;
    logic signed [Z_W-1:0]   b7_reg;
    logic signed [31:0]      n_c;
    logic [31:0]             nabs_c;
    logic [C_N_W-1:0]        nmag_reg;
    logic                    nneg8_reg;
    logic signed [Z_W-1:0]   b8_reg;
    logic                    nneg9_reg;
    logic signed [Z_W-1:0]   b9_reg;
    logic                    nneg10_reg;
    logic signed [Z_W-1:0]   b10_reg;
    logic [C_Q_W-1:0]        cmag;

    // stage: c and b - d
    logic [22:0]             dmag_c;
    logic signed [Z_W:0]     dsgn_c;
    logic signed [Z_W:0]     bd_full;
    logic signed [15:0]      c_c;
    logic signed [15:0]      c11_reg;
    logic signed [BD_W-1:0]  bd11_reg;

    // stage: month index
    logic [BD_W-1:0]         babs_c;
    logic [BMAG_W-1:0]       bmag_c;
    logic [EMAG_W-1:0]       emag_c;
    logic signed [15:0]      c12_reg;
    logic                    bneg12_reg;
    logic [BMAG_W-1:0]       bmag12_reg;
    logic [EMAG_W-1:0]       emag12_reg;

    // stage: final fields
    logic [BMAG_W-1:0]       dpos_c;
    logic signed [5:0]       e_c;
    logic signed [5:0]       m_c;
    logic signed [15:0]      y_c;
    date_t                   date_next;
    date_t                   date_reg;

    assign z_c      = signed'({1'b0, dayq}) - Z_OFFSET;
    assign greg_c   = (z_c >= GREG_START);
    assign nal_full = (26'(z_c) <<< 2) - ALPHA_BASE;
    assign nal_c    = greg_c ? nal_full[ALPHA_N_W-1:0] : '0;

    assign alpha_adj = signed'(Z_W'(alpha) - Z_W'(alpha[ALPHA_Q_W-1:2]));
    assign a_c       = greg6_reg ? z6_reg + 24'sd1 + alpha_adj : z6_reg;

    assign n_c    = 32'(b7_reg) * 32'sd100 - C_BASE;
    assign nabs_c = n_c[31] ? 32'(-n_c) : 32'(n_c);

    // 36525c/100 is 365c plus c/4, both truncated towards zero
    assign dmag_c  = 23'(cmag) * 23'd365 + 23'(cmag[C_Q_W-1:2]);
    assign dsgn_c  = nneg10_reg ? -signed'({2'b00, dmag_c}) : signed'({2'b00, dmag_c});
    assign bd_full = (Z_W+1)'(b10_reg) - dsgn_c;
    assign c_c     = nneg10_reg ? -signed'({1'b0, cmag}) : signed'({1'b0, cmag});

    assign babs_c = bd11_reg[BD_W-1] ? BD_W'(-bd11_reg) : BD_W'(bd11_reg);
    assign bmag_c = babs_c[BMAG_W-1:0];

    always_comb
    begin
        emag_c = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (bmag_c >= E_THRESH[k])
            begin
                emag_c = EMAG_W'(k);
            end
        end
    end

    assign dpos_c = bmag12_reg - E_TERM[emag12_reg];
    assign e_c    = bneg12_reg ? -signed'({2'b00, emag12_reg})
                               : signed'({2'b00, emag12_reg});
    assign m_c    = (e_c <= 6'sd13) ? e_c - 6'sd1 : e_c - 6'sd13;
    assign y_c    = (m_c >= 6'sd3) ? c12_reg - YEAR_LATE : c12_reg - YEAR_EARLY;

    always_comb
    begin
        date_next.year  = y_c[YEAR_W-1:0];
        date_next.month = m_c[MONTH_W-1:0];
        date_next.day   = bneg12_reg ? DAY_W'(BMAG_W'(0) - dpos_c) : dpos_c[DAY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            z4_reg    <= z_c;
            greg4_reg <= greg_c;
            nal_reg   <= nal_c;
        end
        if (adv[1])
        begin
            z5_reg    <= z4_reg;
            greg5_reg <= greg4_reg;
        end
        if (adv[2])
        begin
            z6_reg    <= z5_reg;
            greg6_reg <= greg5_reg;
        end
        if (adv[3])
        begin
            b7_reg <= a_c + B_OFFSET;
        end
        if (adv[4])
        begin
            nmag_reg  <= nabs_c[C_N_W-1:0];
            nneg8_reg <= n_c[31];
            b8_reg    <= b7_reg;
        end
        if (adv[5])
        begin
            nneg9_reg <= nneg8_reg;
            b9_reg    <= b8_reg;
        end
        if (adv[6])
        begin
            nneg10_reg <= nneg9_reg;
            b10_reg    <= b9_reg;
        end
        if (adv[7])
        begin
            c11_reg  <= c_c;
            bd11_reg <= bd_full[BD_W-1:0];
        end
        if (adv[8])
        begin
            c12_reg    <= c11_reg;
            bneg12_reg <= bd11_reg[BD_W-1];
            bmag12_reg <= bmag_c;
            emag12_reg <= emag_c;
        end
        if (adv[9])
        begin
            date_reg <= date_next;
        end
    end

    ep2c_cdiv #(
        .DIVISOR (ALPHA_DIVISOR),
        .N_W     (ALPHA_N_W),
        .Q_W     (ALPHA_Q_W),
        .SHIFT   (ALPHA_SHIFT)
    ) u_alpha_div (
        .clk (clk),
        .adv (adv[2:1]),
        .num (nal_reg),
        .quo (alpha),
        .rmd ()
    );

    ep2c_cdiv #(
        .DIVISOR (C_DIVISOR),
        .N_W     (C_N_W),
        .Q_W     (C_Q_W),
        .SHIFT   (C_SHIFT)
    ) u_c_div (
        .clk (clk),
        .adv (adv[6:5]),
        .num (nmag_reg),
        .quo (cmag),
        .rmd ()
    );

    assign date = date_reg;

endmodule

>>> src/epoch_seconds_to_calendar.sv
// epoch_seconds_to_calendar: 14-stage pipeline, one item per cycle when the
// output is taken; latency is set by the chain of constant divisions in
// the date path (day split, alpha, century), each an estimate stage and a
// correction stage. reset clears the valid bits only; data registers are
// left as they are. uses ep2c_pkg, ep2c_split, ep2c_tod and ep2c_date.
module epoch_seconds_to_calendar (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  epoch_valid,
    output logic                                  epoch_stall,
    input  logic signed [ep2c_pkg::SECS_W-1:0]    epoch_seconds,
    output logic                                  cal_valid,
    input  logic                                  cal_stall,
    output logic [ep2c_pkg::YEAR_W-1:0]           cal_year,
    output logic [ep2c_pkg::MONTH_W-1:0]          cal_month,
    output logic [ep2c_pkg::DAY_W-1:0]            day_of_month,
    output logic [ep2c_pkg::HOUR_W-1:0]           hour_of_day,
    output logic [ep2c_pkg::MINUTE_W-1:0]         minute_of_hour,
    output logic [ep2c_pkg::SECOND_W-1:0]         second_of_minute
);
    import ep2c_pkg::*;

    logic [STAGES-1:0]      valid_reg;
    logic [STAGES-1:0]      valid_next;
    logic [STAGES-1:0]      adv;
    logic [DAYQ_W-1:0]      dayq;
    logic [REM_W-1:0]       rem;
    tod_t                   tod;
    date_t                  date;

    // a stage moves on when it is empty or the next one moves on
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !cal_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = epoch_valid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    ep2c_split u_split (
        .clk           (clk),
        .adv           (adv[SPLIT_LAST:0]),
        .epoch_seconds (epoch_seconds),
        .dayq          (dayq),
        .rem           (rem)
    );

    ep2c_tod u_tod (
        .clk (clk),
        .adv (adv[STAGES-1:SPLIT_LAST+1]),
        .rem (rem),
        .tod (tod)
    );

    ep2c_date u_date (
        .clk  (clk),
        .adv  (adv[STAGES-1:SPLIT_LAST+1]),
        .dayq (dayq),
        .date (date)
    );

    assign epoch_stall      = !adv[0];
    assign cal_valid        = valid_reg[STAGES-1];
    assign cal_year         = date.year;
    assign cal_month        = date.month;
    assign day_of_month     = date.day;
    assign hour_of_day      = tod.hour;
    assign minute_of_hour   = tod.minute;
    assign second_of_minute = tod.second;

    // input is held back only when every stage is full and the output waits
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_stall |-> ((&valid_reg) && cal_stall))
        else $error("input stalled while the pipeline has room");

    // time of day comes from a remainder below one day for any input
    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> (hour_of_day < 5'd24 && minute_of_hour < 6'd60
                       && second_of_minute < 6'd60))
        else $error("time of day out of range");

    // an item may not vanish from the last stage while it waits
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cal_valid && cal_stall) |=> (cal_valid && $stable(date) && $stable(tod)))
        else $error("waiting result lost or changed");

endmodule
